/* rtl/reply_frame_checker_defines.svh */
// Assertion macros for the reply frame checker.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef REPLY_FRAME_CHECKER_DEFINES_SVH
`define REPLY_FRAME_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define RFC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reply_frame_checker: same-cycle check failed");
// Antecedent implies consequent in the next cycle.
`define RFC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reply_frame_checker: next-cycle check failed");
`else
`define RFC_ASSERT_IMP(label, clk, rst, ante, cons)
`define RFC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/rfc_pkg.sv */
// Types and constants for the reply frame checker.
// No dependencies; imported by reply_frame_checker.
`default_nettype none

package rfc_pkg;

  // Frame geometry
  localparam int unsigned MIN_FRAME  = 8;    // smallest total frame, bytes
  localparam int unsigned CAP_FRAME  = 128;  // hard cap on total frame, bytes
  localparam int unsigned OVERHEAD   = 5;    // total minus declared length
  localparam int unsigned HDR_FIELDS = 2;    // type and command inside L

  // Byte positions within a frame
  localparam logic [6:0] POS_START = 7'd0;
  localparam logic [6:0] POS_LEN_H = 7'd1;
  localparam logic [6:0] POS_LEN_L = 7'd2;
  localparam logic [6:0] POS_TYPE  = 7'd3;
  localparam logic [6:0] POS_CMD   = 7'd4;

  // Report status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_BAD_END   = 3'd3;
  localparam logic [2:0] ST_BAD_XOR   = 3'd4;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_MARKER = 2'd0;
  localparam logic [1:0] CFG_END_MARKER   = 2'd1;
  localparam logic [1:0] CFG_MAX_FRAME    = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_DROP = 2'd2
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
    logic [7:0] msg_type;
    logic [7:0] msg_cmd;
    logic [6:0] payload_len;
    logic [2:0] status;
  } result_t;

endpackage

`default_nettype wire

/* rtl/reply_frame_checker.sv */
// Reply frame checker: start marker, 16-bit length, type, command, payload,
// end marker and XOR check byte, one byte per item. Depends on rfc_pkg and
// reply_frame_checker_defines.svh.

// Usage:
//   Input channel (in_valid/in_stall) carries rx_byte and first_flag. A byte
//   with first_flag set opens a new frame and abandons any frame in progress.
//   Output channel (out_valid/out_stall) carries one result per payload byte
//   (kind 0, unconfirmed) and one end-of-frame report (kind 1) with type,
//   command, payload length and status. After a report, bytes are dropped
//   until the next first_flag. Header and end marker bytes that pass give
//   no result; the check byte always ends the frame with a report.
//   A result is registered; it appears the cycle after its byte is accepted.
//   Throughput: one byte per cycle while in_stall is low; the per-byte step
//   is a single pass of compare and XOR logic into the result register.
//   Stall: the result register holds while out_stall is high; in_stall is
//   raised only while a held result waits, so the input keeps flowing when
//   the result register is empty or being taken.
//   Configuration: cfg_valid/cfg_ready, cfg_index, cfg_data, written only
//   while the block is idle (user's duty, unchecked); cfg_ready is always high.
//   Reset (rst, synchronous): registers return to start 2, end 3, max 128;
//   the block waits for a first byte and the result register is empty.
`default_nettype none

`include "reply_frame_checker_defines.svh"

module reply_frame_checker
  import rfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  // input bytes
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       first_flag,
  // results
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            kind,
  output logic [7:0]      payload_byte,
  output logic [6:0]      payload_index,
  output logic [7:0]      msg_type,
  output logic [7:0]      msg_cmd,
  output logic [6:0]      payload_len,
  output logic [2:0]      status
);

  localparam logic [8:0] CAP_LIM   = 9'(CAP_FRAME);
  localparam logic [7:0] MIN_LEN_L = 8'(MIN_FRAME - OVERHEAD);
  localparam logic [8:0] OVH9      = 9'(OVERHEAD);
  localparam logic [7:0] OVH8      = 8'(OVERHEAD);
  localparam logic [6:0] OVH7      = 7'(OVERHEAD);
  localparam logic [6:0] HDR7      = 7'(HDR_FIELDS);

  // Configuration registers
  logic [7:0] start_marker;
  logic [7:0] end_marker;
  logic [7:0] max_frame_bytes;

  // Frame state
  phase_t     phase, phase_next;
  logic [6:0] byte_pos;
  logic [7:0] len_high;
  logic [6:0] declared_len;
  logic [7:0] running_xor;
  logic [7:0] type_hold;
  logic [7:0] cmd_hold;

  logic       accept;
  logic       active;
  logic [6:0] pos;
  logic [7:0] len_cur;
  logic [6:0] decl_cur;
  logic [7:0] xor_cur;
  logic [7:0] type_cur;
  logic [7:0] cmd_cur;
  logic [8:0] lim;
  logic [8:0] total_rx;
  logic [7:0] pos_check;
  logic [7:0] pos_end;
  logic       len_bad;
  result_t    res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker    <= 8'd2;
      end_marker      <= 8'd3;
      max_frame_bytes <= 8'd128;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_MARKER: start_marker    <= cfg_data;
        CFG_END_MARKER:   end_marker      <= cfg_data;
        CFG_MAX_FRAME:    max_frame_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign active   = first_flag || (phase == PH_RECV);

  // A first byte sees a fresh frame state
  assign pos      = first_flag ? POS_START : byte_pos;
  assign len_cur  = first_flag ? 8'd0 : len_high;
  assign decl_cur = first_flag ? 7'd0 : declared_len;
  assign xor_cur  = first_flag ? 8'd0 : running_xor;
  assign type_cur = first_flag ? 8'd0 : type_hold;
  assign cmd_cur  = first_flag ? 8'd0 : cmd_hold;

  assign lim       = ({1'b0, max_frame_bytes} > CAP_LIM) ? CAP_LIM : {1'b0, max_frame_bytes};
  assign total_rx  = {1'b0, rx_byte} + OVH9;
  assign len_bad   = (len_cur != 8'd0) || (rx_byte < MIN_LEN_L) || (total_rx > lim);
  assign pos_check = {1'b0, decl_cur} + OVH8 - 8'd1;
  assign pos_end   = {1'b0, decl_cur} + OVH8 - 8'd2;

  // Result of the per-byte step
  always_comb begin
    res = '0;
    if (active) begin
      case (pos)
        POS_START: begin
          if (rx_byte != start_marker) begin
            res.valid  = 1'b1;
            res.kind   = KIND_REPORT;
            res.status = ST_BAD_START;
          end
        end
        POS_LEN_H, POS_TYPE, POS_CMD: ;
        POS_LEN_L: begin
          if (len_bad) begin
            res.valid  = 1'b1;
            res.kind   = KIND_REPORT;
            res.status = ST_BAD_LEN;
          end
        end
        default: begin
          if ({1'b0, pos} == pos_check) begin
            res.valid       = 1'b1;
            res.kind        = KIND_REPORT;
            res.msg_type    = type_cur;
            res.msg_cmd     = cmd_cur;
            res.payload_len = decl_cur - HDR7;
            res.status      = (xor_cur == rx_byte) ? ST_OK : ST_BAD_XOR;
          end else if ({1'b0, pos} == pos_end) begin
            if (rx_byte != end_marker) begin
              res.valid       = 1'b1;
              res.kind        = KIND_REPORT;
              res.msg_type    = type_cur;
              res.msg_cmd     = cmd_cur;
              res.payload_len = decl_cur - HDR7;
              res.status      = ST_BAD_END;
            end
          end else begin
            res.valid         = 1'b1;
            res.kind          = KIND_PAYLOAD;
            res.payload_byte  = rx_byte;
            res.payload_index = pos - OVH7;
          end
        end
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (accept && active) begin
      if (res.valid && (res.kind == KIND_REPORT)) begin
        phase_next = PH_DROP;
      end else begin
        phase_next = PH_RECV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_pos     <= '0;
      len_high     <= '0;
      declared_len <= '0;
      running_xor  <= '0;
      type_hold    <= '0;
      cmd_hold     <= '0;
    end else begin
      phase <= phase_next;
      if (accept && active) begin
        // Clear the frame record on a new frame, then capture this byte
        byte_pos     <= pos;
        len_high     <= len_cur;
        declared_len <= decl_cur;
        running_xor  <= xor_cur;
        type_hold    <= type_cur;
        cmd_hold     <= cmd_cur;
        if (!(res.valid && (res.kind == KIND_REPORT))) begin
          byte_pos    <= pos + 7'd1;
          running_xor <= xor_cur ^ rx_byte;
          case (pos)
            POS_LEN_H: len_high     <= rx_byte;
            POS_LEN_L: declared_len <= rx_byte[6:0];
            POS_TYPE:  type_hold    <= rx_byte;
            POS_CMD:   cmd_hold     <= rx_byte;
            default: ;
          endcase
        end
      end
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res.valid;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind          <= res.kind;
      payload_byte  <= res.payload_byte;
      payload_index <= res.payload_index;
      msg_type      <= res.msg_type;
      msg_cmd       <= res.msg_cmd;
      payload_len   <= res.payload_len;
      status        <= res.status;
    end
  end

  `RFC_ASSERT_NXT(a_report_drops, clk, rst,
    accept && res.valid && (res.kind == KIND_REPORT), phase == PH_DROP)
  `RFC_ASSERT_IMP(a_payload_clean, clk, rst,
    out_valid && (kind == KIND_PAYLOAD), (status == ST_OK) && (payload_len == 7'd0))
  `RFC_ASSERT_IMP(a_early_report_empty, clk, rst,
    out_valid && (kind == KIND_REPORT) && ((status == ST_BAD_START) || (status == ST_BAD_LEN)),
    (msg_type == 8'd0) && (msg_cmd == 8'd0) && (payload_len == 7'd0))

endmodule

`default_nettype wire

/* bench/tb_reply_frame_checker.sv */
`timescale 1ns / 1ps
// Self-checking bench for reply_frame_checker: framed byte streams in, payload and report out.
// Depends on rfc_pkg and the reply_frame_checker RTL; results are checked against a local tracker.

module tb_reply_frame_checker;
  import rfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned SHOWN_ERRORS = 10;

  // Ways a generated frame can be damaged
  localparam int FAULT_NONE  = 0;
  localparam int FAULT_START = 1;
  localparam int FAULT_LEN   = 2;
  localparam int FAULT_END   = 3;
  localparam int FAULT_XOR   = 4;
  localparam int FAULT_CUT   = 5;

  typedef struct {
    logic [7:0] data;
    logic       first;
  } rx_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
    logic [7:0] msg_type;
    logic [7:0] msg_cmd;
    logic [6:0] payload_len;
    logic [2:0] status;
  } frame_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = '0;
  logic       first_flag = 1'b0;
  logic       out_stall = 1'b0;
  logic       cfg_ready;
  logic       in_stall;
  logic       out_valid;
  logic       kind;
  logic [7:0] payload_byte;
  logic [6:0] payload_index;
  logic [7:0] msg_type;
  logic [7:0] msg_cmd;
  logic [6:0] payload_len;
  logic [2:0] status;

  reply_frame_checker u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .first_flag   (first_flag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .payload_index(payload_index),
    .msg_type     (msg_type),
    .msg_cmd      (msg_cmd),
    .payload_len  (payload_len),
    .status       (status)
  );

  always #2 clk = ~clk;

  rx_item_t    rx_pending_q[$];
  frame_out_t  frame_out_q[$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Register copies and frame tracker state
  logic [7:0] cfg_start = 8'd2;
  logic [7:0] cfg_end = 8'd3;
  logic [7:0] cfg_max = 8'd128;
  phase_t     trk_phase = PH_IDLE;
  logic [6:0] trk_pos = '0;
  logic [7:0] trk_len_hi = '0;
  logic [6:0] trk_decl = '0;
  logic [7:0] trk_xor = '0;
  logic [7:0] trk_type = '0;
  logic [7:0] trk_cmd = '0;

  task push_report(input logic [2:0] code, input logic with_frame);
    frame_out_t r;
    r = '0;
    r.kind = KIND_REPORT;
    if (with_frame) begin
      r.msg_type = trk_type;
      r.msg_cmd = trk_cmd;
      r.payload_len = 7'(trk_decl - HDR_FIELDS);
    end
    r.status = code;
    frame_out_q.push_back(r);
    trk_phase = PH_DROP;
  endtask

  task frame_advance(input logic [7:0] b, input logic first);
    frame_out_t  r;
    int unsigned total;
    int unsigned lim;
    if (first) begin
      trk_phase = PH_RECV;
      trk_pos = '0;
      trk_len_hi = '0;
      trk_decl = '0;
      trk_xor = '0;
      trk_type = '0;
      trk_cmd = '0;
    end else if (trk_phase != PH_RECV) begin
      return;
    end
    case (trk_pos)
      POS_START: begin
        if (b != cfg_start) begin
          push_report(ST_BAD_START, 1'b0);
          return;
        end
      end
      POS_LEN_H: trk_len_hi = b;
      POS_LEN_L: begin
        lim = (cfg_max > CAP_FRAME) ? CAP_FRAME : 32'(cfg_max);
        total = 32'(trk_len_hi) * 256 + 32'(b) + OVERHEAD;
        if (total < MIN_FRAME || total > lim) begin
          push_report(ST_BAD_LEN, 1'b0);
          return;
        end
        trk_decl = 7'(total - OVERHEAD);
      end
      POS_TYPE: trk_type = b;
      POS_CMD:  trk_cmd = b;
      default: begin
        total = 32'(trk_decl) + OVERHEAD;
        if (32'(trk_pos) == total - 1) begin
          push_report((trk_xor == b) ? ST_OK : ST_BAD_XOR, 1'b1);
          return;
        end
        if (32'(trk_pos) == total - 2) begin
          if (b != cfg_end) begin
            push_report(ST_BAD_END, 1'b1);
            return;
          end
        end else begin
          r = '0;
          r.kind = KIND_PAYLOAD;
          r.payload_byte = b;
          r.payload_index = 7'(trk_pos - OVERHEAD);
          frame_out_q.push_back(r);
        end
      end
    endcase
    trk_xor = trk_xor ^ b;
    trk_pos = trk_pos + 7'd1;
  endtask

  task push_item(input logic [7:0] b, input logic first);
    rx_pending_q.push_back('{data: b, first: first});
    items_queued++;
  endtask

  // Build one frame under the current register values, optionally damaged.
  task queue_frame(input int unsigned plen, input int fault, input logic [7:0] typ,
                   input logic [7:0] cmd);
    logic [7:0]  fb[$];
    logic [7:0]  acc;
    int unsigned lim;
    int unsigned maxp;
    int unsigned len_val;
    int unsigned keep;
    lim = (cfg_max > CAP_FRAME) ? CAP_FRAME : 32'(cfg_max);
    maxp = (lim >= MIN_FRAME) ? lim - (OVERHEAD + HDR_FIELDS) : 3;
    if (plen > maxp) plen = maxp;
    if (plen < 1) plen = 1;
    len_val = plen + HDR_FIELDS;
    if (fault == FAULT_LEN) begin
      case ($urandom_range(0, 2))
        0: len_val = $urandom_range(0, HDR_FIELDS);
        1: len_val = (lim >= MIN_FRAME) ? $urandom_range(lim - OVERHEAD + 1, 255)
                                        : $urandom_range(0, 255);
        default: len_val = {8'($urandom_range(1, 255)), 8'($urandom)};
      endcase
    end
    fb.push_back((fault == FAULT_START) ? cfg_start ^ 8'($urandom_range(1, 255)) : cfg_start);
    fb.push_back(len_val[15:8]);
    fb.push_back(len_val[7:0]);
    fb.push_back(typ);
    fb.push_back(cmd);
    repeat (plen) fb.push_back(8'($urandom));
    fb.push_back((fault == FAULT_END) ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end);
    acc = '0;
    foreach (fb[i]) acc = acc ^ fb[i];
    fb.push_back((fault == FAULT_XOR) ? acc ^ 8'($urandom_range(1, 255)) : acc);
    keep = fb.size();
    if (fault == FAULT_START) keep = $urandom_range(1, 3);
    if (fault == FAULT_LEN) keep = 3 + $urandom_range(0, 2);
    if (fault == FAULT_CUT) keep = $urandom_range(1, fb.size() - 1);
    for (int i = 0; i < keep; i++) push_item(fb[i], i == 0);
    // trailing bytes without a first flag are dropped by the block, or continue a cut frame
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) push_item(8'($urandom), 1'b0);
  endtask

  task drain();
    do @(posedge clk);
    while (items_taken != items_queued || frame_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_START_MARKER: cfg_start = val;
      CFG_END_MARKER:   cfg_end = val;
      CFG_MAX_FRAME:    cfg_max = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task run_phase(input logic [7:0] s, input logic [7:0] e, input logic [7:0] m,
                 input int unsigned send_pct, input int unsigned stall_pct,
                 input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned plen;
    int          fault;
    drain();
    write_reg(CFG_START_MARKER, s);
    write_reg(CFG_END_MARKER, e);
    write_reg(CFG_MAX_FRAME, m);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_queued + n;
    while (items_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      plen = $urandom_range(0, 99);
      if (plen < 85) plen = $urandom_range(1, 12);
      else if (plen < 95) plen = $urandom_range(1, 121);
      else plen = 121;
      if (pick < 62) fault = FAULT_NONE;
      else if (pick < 68) fault = FAULT_START;
      else if (pick < 76) fault = FAULT_LEN;
      else if (pick < 83) fault = FAULT_END;
      else if (pick < 90) fault = FAULT_XOR;
      else if (pick < 96) fault = FAULT_CUT;
      else fault = -1;
      if (fault < 0) begin
        repeat ($urandom_range(1, 4)) push_item(8'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        queue_frame(plen, fault, 8'($urandom), 8'($urandom));
      end
    end
    // close with a whole frame so the block sits in drop state before the next writes
    queue_frame($urandom_range(1, 6), FAULT_NONE, 8'($urandom), 8'($urandom));
  endtask

  always @(posedge clk) begin : drive_bytes
    rx_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        frame_advance(rx_byte, first_flag);
        items_taken++;
      end
      // advance only when the current item is gone
      if (!in_valid || !in_stall) begin
        if (rx_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = rx_pending_q.pop_front();
          in_valid <= 1'b1;
          rx_byte <= nxt.data;
          first_flag <= nxt.first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    frame_out_t got;
    frame_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {kind, payload_byte, payload_index, msg_type, msg_cmd, payload_len, status};
        if (frame_out_q.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("unexpected result: kind %0d byte %02h idx %0d type %02h cmd %02h len %0d st %0d",
                     got.kind, got.payload_byte, got.payload_index, got.msg_type,
                     got.msg_cmd, got.payload_len, got.status);
        end else begin
          want = frame_out_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
              $display("mismatch exp: kind %0d byte %02h idx %0d type %02h cmd %02h len %0d st %0d",
                       want.kind, want.payload_byte, want.payload_index, want.msg_type,
                       want.msg_cmd, want.payload_len, want.status);
              $display("         got: kind %0d byte %02h idx %0d type %02h cmd %02h len %0d st %0d",
                       got.kind, got.payload_byte, got.payload_index, got.msg_type,
                       got.msg_cmd, got.payload_len, got.status);
            end
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under reset register values
    push_item(8'h00, 1'b0);
    queue_frame(1, FAULT_NONE, 8'h00, 8'hFF);
    push_item(8'hFF, 1'b1);
    push_item(cfg_start, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h02, 1'b0);
    push_item(cfg_start, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h7C, 1'b0);
    queue_frame(1, FAULT_END, 8'hFF, 8'h00);
    queue_frame(1, FAULT_XOR, 8'h5A, 8'hA5);

    run_phase(8'h00, 8'hFF, 8'd8, 0, 0, 150);
    run_phase(8'hFF, 8'h00, 8'hFF, 59, 0, 165);
    run_phase(8'h55, 8'hAA, 8'd5, 0, 59, 40);
    run_phase(8'($urandom), 8'($urandom), 8'd128, 37, 37, 165);
    run_phase(8'($urandom), 8'($urandom), 8'($urandom_range(8, 200)), 0, 0, 165);
    run_phase(8'h02, 8'h03, 8'd64, 59, 0, 165);
    run_phase(8'h7E, 8'h7E, 8'd0, 0, 59, 40);
    run_phase(8'($urandom), 8'($urandom), 8'd128, 37, 37, 165);

    drain();
    if (mismatches == 0 && frame_out_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* reply_frame_checker.f */
+incdir+rtl
rtl/rfc_pkg.sv
rtl/reply_frame_checker.sv
bench/tb_reply_frame_checker.sv
